>>> rtl/core/lrg_pkg.sv
// Shared constants for the linear resampler with gain.
// No dependencies; imported by the core top level.
package lrg_pkg;

    localparam int FIFO_DEPTH = 4096;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    localparam int SAMPLE_W = 16;
    localparam int STEP_W   = 19;
    localparam int GAIN_W   = 15;
    localparam int PHASE_W  = 20;
    localparam int FRAC_W   = 16;
    localparam int CFG_W    = 19;
    localparam int CFG_IW   = 1;

    localparam int MUL_AW = 32;
    localparam int MUL_BW = 17;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [CFG_IW-1:0] REG_STEP = 1'b0;
    localparam logic [CFG_IW-1:0] REG_GAIN = 1'b1;

    localparam logic [STEP_W-1:0] STEP_RESET = 19'd65536;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd4915;
    localparam logic [GAIN_W-1:0] GAIN_MAX   = 15'd16384;
    localparam logic [MUL_BW-1:0] DECAY_Q15  = 17'd27853;

    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_FRAME = 1'b1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

endpackage

>>> rtl/core/lrg_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the source sample FIFO storage.
module lrg_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/linear_resampler_with_gain_core.sv
// Linear interpolation resampler with Q12 output gain, saturated to 16 bits.
// Push item: written to the FIFO, no result. Frame item: k catch-up pops (0..8) from the
// FIFO, a decayed copy of the last sample standing in for each pop that finds the FIFO
// empty, then interpolation and gain; one shared 32x17 multiplier does decay, interpolation and gain.
// No new item is taken while a frame is in work, also while it waits to load the result register.
// Reset (rst_n, async low) clears pointers, count, phase, samples and flags.
module linear_resampler_with_gain_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         op,
    input  lrg_pkg::sample_t             sample_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output lrg_pkg::sample_t             sample_out,
    output logic                         underrun,
    output logic                         overflow,
    input  logic                         cfg_we,
    input  logic [lrg_pkg::CFG_IW-1:0]   cfg_index,
    input  logic [lrg_pkg::CFG_W-1:0]    cfg_data
);
    import lrg_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CATCH = 3'd1;
    localparam logic [2:0] ST_RDWT  = 3'd2;
    localparam logic [2:0] ST_DEC   = 3'd3;
    localparam logic [2:0] ST_DECWB = 3'd4;
    localparam logic [2:0] ST_MUL1  = 3'd5;
    localparam logic [2:0] ST_SUM   = 3'd6;
    localparam logic [2:0] ST_OUT   = 3'd7;

    localparam logic [FIFO_AW-1:0] PTR_LAST = FIFO_AW'(FIFO_DEPTH - 1);
    localparam logic [FIFO_CW-1:0] CNT_FULL = FIFO_CW'(FIFO_DEPTH);

    logic [2:0]          state_reg, state_next;
    logic                mul2_reg, mul2_next;
    logic [FIFO_AW-1:0]  rptr_reg, rptr_next;
    logic [FIFO_AW-1:0]  wptr_reg, wptr_next;
    logic [FIFO_CW-1:0]  count_reg, count_next;
    logic [PHASE_W-1:0]  phase_reg, phase_next;
    sample_t             cur_reg, cur_next;
    sample_t             nxt_reg, nxt_next;
    logic                ovf_reg, ovf_next;
    logic                under_reg, under_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [GAIN_W-1:0]   gain_reg, gain_next;
    logic signed [MUL_PW-1:0] prod_reg, prod_next;
    logic signed [31:0]  acc_reg, acc_next;
    logic                ovalid_reg, ovalid_next;
    sample_t             sout_reg, sout_next;
    logic                uout_reg, uout_next;
    logic                oout_reg, oout_next;

    logic                ram_we;
    logic                ram_re;
    logic [SAMPLE_W-1:0] ram_rdata;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [SAMPLE_W:0] diff;
    logic [GAIN_W-1:0]        gain_c;
    logic signed [31:0]       dec_p;
    logic signed [31:0]       dec_r;
    logic signed [MUL_PW-1:0] out_r;
    logic signed [MUL_PW-29:0] out_v;
    logic                     accept;
    logic                     out_free;

    lrg_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wptr_reg),
        .wdata (sample_in),
        .re    (ram_re),
        .raddr (rptr_reg),
        .rdata (ram_rdata)
    );

    assign in_ready   = (state_reg == ST_IDLE);
    assign accept     = in_valid && in_ready;
    assign out_valid  = ovalid_reg;
    assign sample_out = sout_reg;
    assign underrun   = uout_reg;
    assign overflow   = oout_reg;
    assign out_free   = !ovalid_reg || out_ready;

    assign diff   = {nxt_reg[SAMPLE_W-1], nxt_reg} - {cur_reg[SAMPLE_W-1], cur_reg};
    assign gain_c = (gain_reg > GAIN_MAX) ? GAIN_MAX : gain_reg;

    // shared multiplier operand select
    always_comb
    begin
        mul_a = acc_reg;
        mul_b = MUL_BW'({2'b00, gain_c});
        if (state_reg == ST_DEC)
        begin
            mul_a = MUL_AW'(cur_reg);
            mul_b = DECAY_Q15;
        end
        else if (state_reg == ST_MUL1)
        begin
            mul_a = MUL_AW'(diff);
            mul_b = MUL_BW'({1'b0, phase_reg[FRAC_W-1:0]});
        end
    end

    // truncation toward zero of the Q15 decay and Q28 output products
    assign dec_p = prod_reg[31:0];
    assign dec_r = (dec_p + (dec_p[31] ? 32'sd32767 : 32'sd0)) >>> 15;
    assign out_r = prod_reg + (prod_reg[MUL_PW-1] ? MUL_PW'(28'hFFF_FFFF) : MUL_PW'(0));
    assign out_v = out_r[MUL_PW-1:28];

    always_comb
    begin
        state_next  = state_reg;
        mul2_next   = mul2_reg;
        rptr_next   = rptr_reg;
        wptr_next   = wptr_reg;
        count_next  = count_reg;
        phase_next  = phase_reg;
        cur_next    = cur_reg;
        nxt_next    = nxt_reg;
        ovf_next    = ovf_reg;
        under_next  = under_reg;
        step_next   = step_reg;
        gain_next   = gain_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        ovalid_next = ovalid_reg;
        sout_next   = sout_reg;
        uout_next   = uout_reg;
        oout_next   = oout_reg;
        ram_we      = 1'b0;
        ram_re      = 1'b0;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_STEP: step_next = cfg_data[STEP_W-1:0];
                REG_GAIN: gain_next = cfg_data[GAIN_W-1:0];
                default:  ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op == OP_PUSH)
                    begin
                        if (count_reg == CNT_FULL)
                        begin
                            ovf_next = 1'b1;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            wptr_next  = (wptr_reg == PTR_LAST) ? '0 : wptr_reg + 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        under_next = 1'b0;
                        state_next = ST_CATCH;
                    end
                end
            end
            ST_CATCH:
            begin
                if (|phase_reg[PHASE_W-1:FRAC_W])
                begin
                    phase_next = phase_reg - PHASE_W'(1 << FRAC_W);
                    cur_next   = nxt_reg;
                    if (count_reg != '0)
                    begin
                        ram_re     = 1'b1;
                        rptr_next  = (rptr_reg == PTR_LAST) ? '0 : rptr_reg + 1'b1;
                        count_next = count_reg - 1'b1;
                        state_next = ST_RDWT;
                    end
                    else
                    begin
                        under_next = 1'b1;
                        state_next = ST_DEC;
                    end
                end
                else
                begin
                    state_next = ST_MUL1;
                end
            end
            ST_RDWT:
            begin
                nxt_next   = ram_rdata;
                state_next = ST_CATCH;
            end
            ST_DEC:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_DECWB;
            end
            ST_DECWB:
            begin
                nxt_next   = dec_r[SAMPLE_W-1:0];
                state_next = ST_CATCH;
            end
            ST_MUL1:
            begin
                prod_next  = mul_a * mul_b;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (!mul2_reg)
                begin
                    acc_next  = {cur_reg, 16'h0000} + prod_reg[31:0];
                    mul2_next = 1'b1;
                end
                else
                begin
                    prod_next  = mul_a * mul_b;
                    mul2_next  = 1'b0;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    priority if (out_v > 21'sd32767)
                        sout_next = 16'sh7FFF;
                    else if (out_v < -21'sd32768)
                        sout_next = 16'sh8000;
                    else
                        sout_next = out_v[SAMPLE_W-1:0];
                    uout_next   = under_reg;
                    oout_next   = ovf_reg;
                    ovf_next    = 1'b0;
                    ovalid_next = 1'b1;
                    phase_next  = phase_reg + PHASE_W'(step_reg);
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            mul2_reg   <= 1'b0;
            rptr_reg   <= '0;
            wptr_reg   <= '0;
            count_reg  <= '0;
            phase_reg  <= '0;
            cur_reg    <= '0;
            nxt_reg    <= '0;
            ovf_reg    <= 1'b0;
            under_reg  <= 1'b0;
            step_reg   <= STEP_RESET;
            gain_reg   <= GAIN_RESET;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mul2_reg   <= mul2_next;
            rptr_reg   <= rptr_next;
            wptr_reg   <= wptr_next;
            count_reg  <= count_next;
            phase_reg  <= phase_next;
            cur_reg    <= cur_next;
            nxt_reg    <= nxt_next;
            ovf_reg    <= ovf_next;
            under_reg  <= under_next;
            step_reg   <= step_next;
            gain_reg   <= gain_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        sout_reg <= sout_next;
        uout_reg <= uout_next;
        oout_reg <= oout_next;
    end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for linear_resampler_with_gain_core: push and frame items go
// against an in-bench Q16 phase / Q12 gain predictor, with random stalls on both sides.
// Depends on lrg_pkg and the core RTL only.
module testbench;
    import lrg_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 32;
    localparam int STALL_LIMIT   = 2000;
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_AFTER    = 150;
    localparam int GAIN_FRAC     = 12;

    localparam logic [PHASE_W-1:0] UNITY = PHASE_W'(1 << FRAC_W);
    localparam sample_t S_MAX = 16'sh7FFF;
    localparam sample_t S_MIN = 16'sh8000;

    typedef struct packed {
        logic    op;
        sample_t sample;
    } src_item_t;

    typedef struct packed {
        sample_t sample;
        logic    underrun;
        logic    overflow;
    } frame_res_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_ready;
    logic              op        = OP_PUSH;
    sample_t           sample_in = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    sample_t           sample_out;
    logic              underrun;
    logic              overflow;
    logic              cfg_we    = 1'b0;
    logic [CFG_IW-1:0] cfg_index = REG_STEP;
    logic [CFG_W-1:0]  cfg_data  = '0;

    // predictor state
    sample_t            fifo_q[$];
    logic [PHASE_W-1:0] phase     = '0;
    sample_t            left_s    = '0;
    sample_t            right_s   = '0;
    logic               drop_flag = 1'b0;
    logic [STEP_W-1:0]  step_cfg  = STEP_RESET;
    logic [GAIN_W-1:0]  gain_cfg  = GAIN_RESET;

    src_item_t   src_pending[$];
    frame_res_t  frame_expect[$];
    int unsigned src_gap        = 0;
    int unsigned sink_hold      = 0;
    int unsigned frames_seen    = 0;
    int unsigned quiet_cycles   = 0;
    int          errors         = 0;
    logic        long_hold_done = 1'b0;
    logic        calm           = 1'b0;

    linear_resampler_with_gain_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .op         (op),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .underrun   (underrun),
        .overflow   (overflow),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #(CLK_HALF) clk = ~clk;

    // 0.85 in Q15, truncated toward zero
    function automatic sample_t fade85(input sample_t s);
        int p;
        p = int'(s) * int'(DECAY_Q15);
        if (p < 0)
            return sample_t'(-((-p) >>> 15));
        return sample_t'(p >>> 15);
    endfunction

    task automatic model_accept(input src_item_t it);
        frame_res_t        r;
        logic [GAIN_W-1:0] g;
        longint            acc;
        longint            mag;
        longint            val;
        if (it.op == OP_PUSH)
        begin
            if (fifo_q.size() >= FIFO_DEPTH)
                drop_flag = 1'b1;
            else
                fifo_q.push_back(it.sample);
        end
        else
        begin
            r.underrun = 1'b0;
            while (phase >= UNITY)
            begin
                phase  = phase - UNITY;
                left_s = right_s;
                if (fifo_q.size() > 0)
                    right_s = fifo_q.pop_front();
                else
                begin
                    right_s    = fade85(left_s);
                    r.underrun = 1'b1;
                end
            end
            g   = (gain_cfg > GAIN_MAX) ? GAIN_MAX : gain_cfg;
            acc = longint'(left_s) * 65536
                + (longint'(right_s) - longint'(left_s)) * longint'(phase);
            acc = acc * longint'(g);
            mag = (acc < 0) ? -acc : acc;
            mag = mag >> (FRAC_W + GAIN_FRAC);
            val = (acc < 0) ? -mag : mag;
            if (val > longint'(S_MAX))
                val = longint'(S_MAX);
            else if (val < longint'(S_MIN))
                val = longint'(S_MIN);
            r.sample   = sample_t'(val);
            r.overflow = drop_flag;
            drop_flag  = 1'b0;
            phase      = phase + PHASE_W'(step_cfg);
            frame_expect.push_back(r);
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                model_accept(src_item_t'{op, sample_in});
            if (!in_valid || in_ready)
            begin
                if (src_gap != 0)
                begin
                    in_valid <= 1'b0;
                    src_gap  <= src_gap - 1;
                end
                else if (src_pending.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    op        <= src_pending[0].op;
                    sample_in <= src_pending[0].sample;
                    src_pending.delete(0);
                    if (!calm && $urandom_range(0, 3) == 0)
                        src_gap <= $urandom_range(1, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver; one long hold to back the block up into its input
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (sink_hold != 0)
            begin
                out_ready <= 1'b0;
                sink_hold <= sink_hold - 1;
            end
            else if (!long_hold_done && frames_seen >= HOLD_AFTER)
            begin
                out_ready      <= 1'b0;
                sink_hold      <= LONG_HOLD;
                long_hold_done <= 1'b1;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                sink_hold <= $urandom_range(0, 2);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin : check_results
        frame_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            frames_seen <= frames_seen + 1;
            if (frame_expect.size() == 0)
            begin
                $error("unexpected item: sample_out %0d", sample_out);
                errors++;
            end
            else
            begin
                want = frame_expect.pop_front();
                if (sample_out !== want.sample)
                begin
                    $error("sample_out: expected %0d, got %0d", want.sample, sample_out);
                    errors++;
                end
                if (underrun !== want.underrun)
                begin
                    $error("underrun: expected %0b, got %0b", want.underrun, underrun);
                    errors++;
                end
                if (overflow !== want.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", want.overflow, overflow);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("testbench: done, errors");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic add_item(input logic o, input sample_t s);
        src_pending.push_back(src_item_t'{o, s});
    endtask

    function automatic sample_t any_sample();
        case ($urandom_range(0, 7))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return sample_t'(int'($urandom_range(0, 8)) - 4);
            default: return sample_t'($urandom);
        endcase
    endfunction

    // pushes roughly matched to the step so the FIFO wanders around its level
    task automatic add_traffic(input int n_items);
        int budget;
        int n_push;
        budget = n_items;
        while (budget > 0)
        begin
            n_push = int'(step_cfg >> FRAC_W);
            if ($urandom_range(0, 65535) < step_cfg[FRAC_W-1:0])
                n_push++;
            if ($urandom_range(0, 5) == 0)
                n_push = $urandom_range(0, 2 * n_push + 1);
            repeat (n_push)
                add_item(OP_PUSH, any_sample());
            add_item(OP_FRAME, any_sample());
            budget -= n_push + 1;
        end
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (src_pending.size() != 0 || in_valid || frame_expect.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx == REG_STEP)
            step_cfg = val[STEP_W-1:0];
        else
            gain_cfg = val[GAIN_W-1:0];
    endtask

    task automatic configure(input logic [STEP_W-1:0] st, input logic [GAIN_W-1:0] gn);
        wait_idle();
        write_reg(REG_STEP, CFG_W'(st));
        write_reg(REG_GAIN, CFG_W'(gn));
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset settings: empty start, extremes, drain into decay
        add_item(OP_FRAME, '0);
        add_item(OP_FRAME, S_MAX);
        add_item(OP_PUSH, S_MAX);
        add_item(OP_PUSH, S_MIN);
        add_item(OP_PUSH, sample_t'(-1));
        add_item(OP_PUSH, sample_t'(1));
        add_item(OP_PUSH, '0);
        repeat (6) add_item(OP_FRAME, '0);
        add_item(OP_PUSH, S_MAX);
        repeat (3) add_item(OP_FRAME, S_MIN);
        add_item(OP_PUSH, S_MIN);
        add_item(OP_PUSH, sample_t'(-3));
        repeat (4) add_item(OP_FRAME, '0);

        configure(STEP_RESET, GAIN_W'(1 << GAIN_FRAC));
        add_traffic(400);
        configure(19'd1, 15'd0);
        add_traffic(150);
        configure(19'd0, 15'd32767);
        add_traffic(150);
        repeat (3)
        begin
            configure(STEP_W'($urandom_range(1, 524287)), GAIN_W'($urandom_range(0, 32767)));
            add_traffic(300);
        end

        // fastest step, fill past full for drops, no idling from here on
        configure(19'd524287, GAIN_MAX);
        calm <= 1'b1;
        repeat (FIFO_DEPTH - fifo_q.size() + 3)
            add_item(OP_PUSH, any_sample());
        add_traffic(300);

        wait_idle();
        if (errors == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
